@@ sv/msad_pkg.sv @@
// Shared types and constants of the meter sample averager and decimator.
`default_nettype none

package msad_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W    = 40;
	localparam int VALUE_W     = 32;
	localparam int HOLD_W      = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Operation codes carried in the op field.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MIN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MAX  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT = 2'd2;

	// Reset values of the configuration registers.
	localparam logic signed [VALUE_W-1:0] VALUE_MIN_RESET  = -32'sd2147483647;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX_RESET  = 32'sd2147483647;
	localparam logic [HOLD_W-1:0]         HOLD_LIMIT_RESET = 4'd4;

	// Tick sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LDIV,
		ST_LSGN,
		ST_LCLMP,
		ST_ACC,
		ST_HCHK,
		ST_HDIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/msad_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock cycle.
`default_nettype none

module msad_div #(
	parameter int DIVIDEND_W = 56,
	parameter int DIVISOR_W  = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quot,
	output logic [DIVISOR_W-1:0]       rem
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;

	logic [DIVISOR_W:0]    partial;
	logic [DIVISOR_W+1:0]  diff;
	logic                  ge;

	// The dividend shifts out of the top of quot_q while quotient bits enter at the bottom.
	assign partial = {rem_q, quot_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, partial} - {2'b00, divisor_q};
	assign ge      = ~diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIVIDEND_W-2:0], ge};
			rem_q  <= ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	// A new division is only started once the previous one has finished.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	// The result is flagged in the cycle after the last busy cycle, once busy has dropped.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("divider done without a preceding run");

	// A finished remainder is always below the divisor.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ sv/meter_sample_averager_decimator.sv @@
// Top level of the meter sample averager and decimator.
`default_nettype none

// The block keeps a running sum and count of meter readings (signed fixed point with
// FRAC_BITS fraction bits) and turns them into one result beat per tick. A sample beat
// is accepted while the sequencer is idle and gives no result; readings flagged as
// not-a-number, and readings that arrive once the pending count is full, are dropped.
// A tick beat divides the pending sum by the pending count times 2^FRAC_BITS in a
// bit-serial divider, rounds half away from zero and clamps to [value_min, value_max]
// (value_max wins if the bounds cross). With no pending samples the last live value is
// repeated hold_limit times and then reported as invalid. Valid live values are summed
// per interval; a tick with close_interval set also divides that sum by its count,
// truncating toward zero, and restarts the interval. The same divider serves both
// divisions and produces one quotient bit per cycle, so it sets the rate: a tick with
// pending samples runs one division, and closing a non-empty interval runs one more.
// The input channel is ready only while no tick is in progress. The result sits in an
// output register, so the next beat can be taken while it waits downstream.
// Configuration writes are always accepted; an index beyond the register list is ignored.

module meter_sample_averager_decimator
	import msad_pkg::*;
#(
	parameter int FRAC_BITS  = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,

	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       op,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic                       sample_is_nan,
	input  wire logic                       close_interval,

	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [VALUE_W-1:0]       live_value,
	output logic                            live_valid,
	output logic                            history_updated,
	output logic signed [VALUE_W-1:0]       history_value,
	output logic                            history_valid
);

	localparam int SUM_W  = SAMPLE_W + COUNT_BITS;
	localparam int ISUM_W = VALUE_W + COUNT_BITS;
	localparam int DVW    = COUNT_BITS + FRAC_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Configuration registers.
	logic signed [VALUE_W-1:0] value_min_q;
	logic signed [VALUE_W-1:0] value_max_q;
	logic [HOLD_W-1:0]         hold_limit_q;

	// Averaging state.
	logic [COUNT_BITS-1:0]     pending_count_q;
	logic signed [SUM_W-1:0]   pending_sum_q;
	logic signed [VALUE_W-1:0] held_value_q;
	logic [HOLD_W-1:0]         hold_remaining_q;
	logic signed [ISUM_W-1:0]  interval_sum_q;
	logic [COUNT_BITS-1:0]     interval_count_q;

	// Per-tick working registers.
	state_t                    state_q, state_d;
	logic                      close_q;
	logic signed [SUM_W:0]     wide_q;
	logic signed [VALUE_W-1:0] live_q;
	logic                      live_ok_q;
	logic signed [VALUE_W-1:0] hist_q;
	logic                      hist_ok_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] live_value_q;
	logic                      live_valid_q;
	logic                      history_updated_q;
	logic signed [VALUE_W-1:0] history_value_q;
	logic                      history_valid_q;

	// Control from the sequencer.
	logic in_accept;
	logic div_start;
	logic out_load;

	// Divider connection.
	logic             div_done;
	logic [SUM_W-1:0] div_dividend;
	logic [DVW-1:0]   div_divisor;
	logic [SUM_W-1:0] div_quot;
	logic [DVW-1:0]   div_rem;

	// Datapath helpers.
	logic [DVW-1:0]          live_divisor;
	logic [SUM_W-1:0]        pending_mag;
	logic [ISUM_W-1:0]       interval_mag;
	logic                    round_up;
	logic signed [SUM_W:0]   min_ext;
	logic signed [SUM_W:0]   max_ext;
	logic signed [SUM_W:0]   raised;
	logic signed [SUM_W:0]   clamped;
	logic [VALUE_W-1:0]      hist_mag;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q  <= VALUE_MIN_RESET;
			value_max_q  <= VALUE_MAX_RESET;
			hold_limit_q <= HOLD_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VALUE_MIN:  value_min_q  <= $signed(cfg_data);
				REG_VALUE_MAX:  value_max_q  <= $signed(cfg_data);
				REG_HOLD_LIMIT: hold_limit_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Divider operands: magnitude of the pending sum over count * 2^FRAC_BITS for the live
	// value, magnitude of the interval sum over its count for the history value.
	assign live_divisor = DVW'(pending_count_q) << FRAC_BITS;
	assign pending_mag  = pending_sum_q[SUM_W-1] ? (SUM_W'(0) - SUM_W'(pending_sum_q))
	                                             : SUM_W'(pending_sum_q);
	assign interval_mag = interval_sum_q[ISUM_W-1] ? (ISUM_W'(0) - ISUM_W'(interval_sum_q))
	                                               : ISUM_W'(interval_sum_q);
	assign div_dividend = (state_q == ST_IDLE) ? pending_mag : SUM_W'(interval_mag);
	assign div_divisor  = (state_q == ST_IDLE) ? live_divisor : DVW'(interval_count_q);

	msad_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Half away from zero: round the magnitude up when twice the remainder reaches the divisor.
	assign round_up = {div_rem, 1'b0} >= {1'b0, live_divisor};

	// Raise to value_min first, then lower to value_max, so value_max wins on crossed bounds.
	assign min_ext = {{(SUM_W + 1 - VALUE_W){value_min_q[VALUE_W-1]}}, value_min_q};
	assign max_ext = {{(SUM_W + 1 - VALUE_W){value_max_q[VALUE_W-1]}}, value_max_q};
	assign raised  = (wide_q < min_ext) ? min_ext : wide_q;
	assign clamped = (raised > max_ext) ? max_ext : raised;

	assign hist_mag = div_quot[VALUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && op == OP_TICK) begin
					if (pending_count_q != '0) begin
						div_start = 1'b1;
						state_d   = ST_LDIV;
					end else begin
						state_d = ST_ACC;
					end
				end
			end
			ST_LDIV: begin
				if (div_done) begin
					state_d = ST_LSGN;
				end
			end
			ST_LSGN:  state_d = ST_LCLMP;
			ST_LCLMP: state_d = ST_ACC;
			ST_ACC:   state_d = close_q ? ST_HCHK : ST_DONE;
			ST_HCHK: begin
				if (interval_count_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_HDIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_HDIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Averaging state is control state: it decides what later beats produce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_count_q  <= '0;
			pending_sum_q    <= '0;
			held_value_q     <= '0;
			hold_remaining_q <= '0;
			interval_sum_q   <= '0;
			interval_count_q <= '0;
		end else begin
			if (in_accept && op == OP_SAMPLE && !sample_is_nan
			    && pending_count_q != COUNT_MAX) begin
				pending_sum_q   <= pending_sum_q + SUM_W'(sample_value);
				pending_count_q <= pending_count_q + COUNT_BITS'(1);
			end
			if (in_accept && op == OP_TICK && pending_count_q == '0
			    && hold_remaining_q != '0) begin
				hold_remaining_q <= hold_remaining_q - HOLD_W'(1);
			end
			if (state_q == ST_LCLMP) begin
				held_value_q     <= VALUE_W'(clamped);
				hold_remaining_q <= hold_limit_q;
				pending_sum_q    <= '0;
				pending_count_q  <= '0;
			end
			if (state_q == ST_ACC && live_ok_q && interval_count_q != COUNT_MAX) begin
				interval_sum_q   <= interval_sum_q + ISUM_W'(live_q);
				interval_count_q <= interval_count_q + COUNT_BITS'(1);
			end
			if ((state_q == ST_HCHK && interval_count_q == '0)
			    || (state_q == ST_HDIV && div_done)) begin
				interval_sum_q   <= '0;
				interval_count_q <= '0;
			end
		end
	end

	// Per-tick working registers.
	always_ff @(posedge clk) begin
		if (in_accept && op == OP_TICK) begin
			close_q   <= close_interval;
			hist_q    <= '0;
			hist_ok_q <= 1'b0;
			if (pending_count_q == '0 && hold_remaining_q != '0) begin
				live_q    <= held_value_q;
				live_ok_q <= 1'b1;
			end else begin
				live_q    <= '0;
				live_ok_q <= 1'b0;
			end
		end
		if (state_q == ST_LDIV && div_done) begin
			wide_q <= $signed({1'b0, div_quot} + (SUM_W + 1)'(round_up));
		end
		if (state_q == ST_LSGN && pending_sum_q[SUM_W-1]) begin
			wide_q <= -wide_q;
		end
		if (state_q == ST_LCLMP) begin
			live_q    <= VALUE_W'(clamped);
			live_ok_q <= 1'b1;
		end
		if (state_q == ST_HDIV && div_done) begin
			hist_q    <= interval_sum_q[ISUM_W-1] ? $signed(VALUE_W'(0) - hist_mag)
			                                      : $signed(hist_mag);
			hist_ok_q <= 1'b1;
		end
	end

	// Output register: loaded when a tick finishes, emptied when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			live_value_q      <= live_q;
			live_valid_q      <= live_ok_q;
			history_updated_q <= close_q;
			history_value_q   <= hist_q;
			history_valid_q   <= hist_ok_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign live_value      = live_value_q;
	assign live_valid      = live_valid_q;
	assign history_updated = history_updated_q;
	assign history_value   = history_value_q;
	assign history_valid   = history_valid_q;

	// A finished tick always fills an empty output register.
	a_done_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished tick did not fill the output register");

	// Once a tick result is handed over, no pending samples remain.
	a_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (pending_count_q == '0))
		else $error("pending samples survived a tick");

	// A valid history value only comes with a closed interval.
	a_hist_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && history_valid_q) |-> history_updated_q)
		else $error("history value without a closed interval");

	// An invalid live value reads as zero.
	a_live_null: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !live_valid_q) |-> (live_value_q == '0))
		else $error("invalid live value is not zero");

endmodule

`default_nettype wire
